### hw/rtl/cas_pkg.sv
package cas_pkg;

    // Field and state widths.
    localparam int CELL_MV_W    = 16;
    localparam int SUM_W        = 24;
    localparam int COUNT_W      = 9;
    localparam int SOC_W        = 14;
    localparam int MAX_CELLS    = 128;

    // Shared divider geometry: dividend and divisor widths, one quotient bit per step.
    localparam int DIV_W        = 24;
    localparam int DSR_W        = 9;
    localparam int DIV_CNT_W    = 5;

    // Table geometry.
    localparam int TABLE_POINTS = 21;
    localparam int SEG_W        = 5;
    localparam int DIFF_W       = 10;
    localparam int NUM_W        = 19;
    localparam int QUO_SOC_W    = 9;

    // Mapping constants.
    localparam logic [CELL_MV_W-1:0] MV_TOP    = 16'd4200;
    localparam logic [CELL_MV_W-1:0] MV_BOTTOM = 16'd3300;
    localparam logic [SOC_W-1:0]     SOC_FULL  = 14'd10000;
    localparam logic [SOC_W-1:0]     SOC_EMPTY = 14'd0;
    localparam int                   SOC_STEP  = 500;

    // One input transaction.
    typedef struct packed {
        logic [CELL_MV_W-1:0] cell_mv;
        logic                 last_cell;
    } cell_item_t;

    // One result transaction.
    typedef struct packed {
        logic [SOC_W-1:0]     soc_centi;
        logic [CELL_MV_W-1:0] average_mv;
    } soc_item_t;

    // A closed set handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
    } set_entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Request to the shared divider.
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // Open-circuit voltage of table point idx, from 4200 mV down to 3300 mV.
    function automatic logic [CELL_MV_W-1:0] ocv_point(input logic [SEG_W-1:0] idx);
        logic [CELL_MV_W-1:0] mv;
        case (idx)
            5'd0:    mv = 16'd4200;
            5'd1:    mv = 16'd4180;
            5'd2:    mv = 16'd4150;
            5'd3:    mv = 16'd4100;
            5'd4:    mv = 16'd4050;
            5'd5:    mv = 16'd4000;
            5'd6:    mv = 16'd3920;
            5'd7:    mv = 16'd3870;
            5'd8:    mv = 16'd3820;
            5'd9:    mv = 16'd3780;
            5'd10:   mv = 16'd3750;
            5'd11:   mv = 16'd3700;
            5'd12:   mv = 16'd3670;
            5'd13:   mv = 16'd3630;
            5'd14:   mv = 16'd3600;
            5'd15:   mv = 16'd3570;
            5'd16:   mv = 16'd3530;
            5'd17:   mv = 16'd3480;
            5'd18:   mv = 16'd3420;
            5'd19:   mv = 16'd3350;
            5'd20:   mv = 16'd3300;
            default: mv = 16'd0;
        endcase
        return mv;
    endfunction

    // State of charge at the low end of segment seg, in hundredths of a percent.
    function automatic logic [SOC_W-1:0] soc_base(input logic [SEG_W-1:0] seg);
        return SOC_W'(SOC_STEP * (TABLE_POINTS - 2 - int'(seg)));
    endfunction

endpackage

### hw/rtl/cas_front.sv
module cas_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cell_valid,
    output logic                     cell_ready,
    input  cas_pkg::cell_item_t      cell_data,
    input  cas_pkg::queue_status_t   q_status,
    output logic                     q_push,
    output cas_pkg::set_entry_t      q_entry
);
    import cas_pkg::*;

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               accept;
    logic               room;
    logic [SUM_W-1:0]   sum_add;
    logic [COUNT_W-1:0] count_add;

    // A transaction is taken whenever the queue can hold a closed set.
    assign cell_ready = !q_status.full;
    assign accept     = cell_valid && cell_ready;

    // Cells beyond the limit are dropped from the sum and the count.
    assign room      = count_reg < COUNT_W'(MAX_CELLS);
    assign sum_add   = room ? (sum_reg + SUM_W'(cell_data.cell_mv)) : sum_reg;
    assign count_add = room ? (count_reg + COUNT_W'(1)) : count_reg;

    // The closing cell pushes the finished set and clears the accumulator.
    assign q_push        = accept && cell_data.last_cell;
    assign q_entry.sum   = sum_add;
    assign q_entry.count = count_add;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (cell_data.last_cell)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_add;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

### hw/rtl/cas_queue.sv
module cas_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  cas_pkg::set_entry_t      push_entry,
    input  logic                     pop,
    output cas_pkg::set_entry_t      head,
    output cas_pkg::queue_status_t   status
);
    import cas_pkg::*;

    set_entry_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  fill_reg;
    logic [1:0]  fill_next;

    assign status.full  = fill_reg == 2'd2;
    assign status.empty = fill_reg == 2'd0;
    assign head         = slot_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping; push and pop may meet in one cycle.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/cas_divider.sv
module cas_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  cas_pkg::div_req_t   req,
    output cas_pkg::div_rsp_t   rsp
);
    import cas_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     rem_next;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     quo_next;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DSR_W-1:0]     dsr_next;
    logic [DSR_W:0]       trial;
    logic                 fits;

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

### hw/rtl/cas_back.sv
module cas_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cas_pkg::queue_status_t   q_status,
    input  cas_pkg::set_entry_t      q_head,
    output logic                     q_pop,
    output cas_pkg::div_req_t        div_req,
    input  cas_pkg::div_rsp_t        div_rsp,
    output logic                     soc_valid,
    input  logic                     soc_ready,
    output cas_pkg::soc_item_t       soc_data
);
    import cas_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV1 = 3'd1;
    localparam logic [2:0] S_SEG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV2 = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [CELL_MV_W-1:0] avg_reg;
    logic [CELL_MV_W-1:0] avg_next;
    logic [SEG_W-1:0]     seg_reg;
    logic [SEG_W-1:0]     seg_next;
    logic [SOC_W-1:0]     soc_reg;
    logic [SOC_W-1:0]     soc_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    soc_item_t            out_data_reg;
    soc_item_t            out_data_next;
    logic [SEG_W-1:0]     seg_hit;
    logic [CELL_MV_W-1:0] seg_hi_mv;
    logic [CELL_MV_W-1:0] seg_lo_mv;
    logic [CELL_MV_W-1:0] avg_diff;
    logic [NUM_W-1:0]     numer;
    logic [DSR_W-1:0]     span;
    logic                 out_free;

    assign soc_valid = out_valid_reg;
    assign soc_data  = out_data_reg;
    assign out_free  = !out_valid_reg || soc_ready;

    // Segment search: the table falls strictly, so at most one segment matches.
    always_comb
    begin
        seg_hit = '0;
        for (int k = 0; k < TABLE_POINTS - 1; k++)
        begin
            if (avg_reg <= ocv_point(SEG_W'(k)) && avg_reg > ocv_point(SEG_W'(k + 1)))
            begin
                seg_hit = SEG_W'(k);
            end
        end
    end

    // Interpolation operands for the chosen segment.
    assign seg_hi_mv = ocv_point(seg_reg);
    assign seg_lo_mv = ocv_point(seg_reg + SEG_W'(1));
    assign avg_diff  = avg_reg - seg_lo_mv;
    assign numer     = NUM_W'(SOC_STEP) * NUM_W'(avg_diff[DIFF_W-1:0]);
    assign span      = DSR_W'(seg_hi_mv - seg_lo_mv);

    // Divider requests: first the mean, then the interpolation fraction.
    always_comb
    begin
        q_pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(numer);
        div_req.divisor  = span;
        if (state_reg == S_IDLE && !q_status.empty)
        begin
            q_pop            = 1'b1;
            div_req.start    = 1'b1;
            div_req.dividend = q_head.sum;
            div_req.divisor  = q_head.count;
        end
        else if (state_reg == S_MUL)
        begin
            div_req.start = 1'b1;
        end
    end

    // Sequencer for one closed set.
    always_comb
    begin
        state_next     = state_reg;
        avg_next       = avg_reg;
        seg_next       = seg_reg;
        soc_next       = soc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (soc_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[CELL_MV_W-1:0];
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                seg_next = seg_hit;
                if (avg_reg >= MV_TOP)
                begin
                    soc_next   = SOC_FULL;
                    state_next = S_FIN;
                end
                else if (avg_reg <= MV_BOTTOM)
                begin
                    soc_next   = SOC_EMPTY;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    soc_next   = soc_base(seg_reg)
                               + SOC_W'(div_rsp.quotient[QUO_SOC_W-1:0]);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.soc_centi  = soc_reg;
                    out_data_next.average_mv = avg_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg      <= avg_next;
        seg_reg      <= seg_next;
        soc_reg      <= soc_next;
        out_data_reg <= out_data_next;
    end

endmodule

### hw/rtl/cell_average_soc_interpolator.sv
// Channel   Direction  Handshake                Payload
// cell      in         cell_valid / cell_ready  cell_data (cell_mv, last_cell)
// soc       out        soc_valid / soc_ready    soc_data (soc_centi, average_mv)
//
// The front takes cell transactions and keeps accepting while the back works. A closed set
// passes from the queue through the back to a valid result by way of the shared divider,
// which gives one quotient bit per cycle: 24 steps for the mean and, when the mean lies
// inside the table, 24 more for the interpolation. Two closed sets may wait in the queue;
// every cell stalls while it is full, and the back holds a finished set while the result
// register is occupied. Reset clears the sum, count, queue and sequencer.
module cell_average_soc_interpolator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cell_valid,
    output logic                 cell_ready,
    input  cas_pkg::cell_item_t  cell_data,
    output logic                 soc_valid,
    input  logic                 soc_ready,
    output cas_pkg::soc_item_t   soc_data
);
    import cas_pkg::*;

    queue_status_t q_status;
    logic          q_push;
    logic          q_pop;
    set_entry_t    q_entry;
    set_entry_t    q_head;
    div_req_t      div_req;
    div_rsp_t      div_rsp;

    // Front: accumulates cells and closes sets.
    cas_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cell_valid (cell_valid),
        .cell_ready (cell_ready),
        .cell_data  (cell_data),
        .q_status   (q_status),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    // Queue of closed sets between the two sides.
    cas_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .status     (q_status)
    );

    // Shared iterative divider.
    cas_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Back: mean, table lookup, interpolation and result register.
    cas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .soc_valid (soc_valid),
        .soc_ready (soc_ready),
        .soc_data  (soc_data)
    );

`ifndef SYNTHESIS
    // A full queue must hold off new cells.
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !cell_ready)
        else $error("cell_ready high while the set queue is full");

    // Results stay within the charge range.
    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        soc_valid |-> soc_data.soc_centi <= SOC_FULL)
        else $error("soc_centi above full charge");

    // A mean at or above the top point reads as full.
    a_soc_top: assert property (@(posedge clk) disable iff (!rst_n)
        soc_valid && soc_data.average_mv >= MV_TOP |-> soc_data.soc_centi == SOC_FULL)
        else $error("high mean did not give full charge");

    // A mean at or below the bottom point reads as empty.
    a_soc_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        soc_valid && soc_data.average_mv <= MV_BOTTOM |-> soc_data.soc_centi == SOC_EMPTY)
        else $error("low mean did not give zero charge");
`endif

endmodule
